FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the port-level checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Non-overlapping implication, consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dpsz_pkg.sv
// ---------------------------------------------------------------------------
// dpsz_pkg
// Types and constants of the depth point splat z-buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package dpsz_pkg;

  localparam int COORD_W    = 10;
  localparam int CFG_W      = 11;
  localparam int OUT_DEPTH_W = 24;
  localparam int TAG_W      = 2;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_STEREO = 2'd1,
    MODE_LIDAR  = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  localparam logic [TAG_W-1:0] TAG_NONE   = 2'd0;
  localparam logic [TAG_W-1:0] TAG_STEREO = 2'd1;
  localparam logic [TAG_W-1:0] TAG_LIDAR  = 2'd2;

  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef struct packed {
    logic                   status;
    logic                   was_written;
    logic [TAG_W-1:0]       source_out;
    logic [OUT_DEPTH_W-1:0] depth_out;
  } result_t;

endpackage

`default_nettype wire

FILE: design/dpsz_mem.sv
// ---------------------------------------------------------------------------
// dpsz_mem
// Pixel store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module dpsz_mem #(
  parameter int DEPTH = 1048576,
  parameter int AW    = 20,
  parameter int DW    = 26
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read sees the contents before a write at the same edge.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/dpsz_outq.sv
// ---------------------------------------------------------------------------
// dpsz_outq
// Three-entry result queue between the update stage and the output port.
// ---------------------------------------------------------------------------
`default_nettype none

module dpsz_outq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire dpsz_pkg::result_t push_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dpsz_pkg::result_t      out_data,
  output logic [1:0]             count
);

  dpsz_pkg::result_t entries [3];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic       pop;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 2'd0;
      wr_ptr <= 2'd0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

FILE: design/depth_point_splat_zbuffer.sv
// A request is registered into the update stage with its pixel read from the store; its
// result then enters the output queue. Throughput: one point or read request per cycle
// while the output queue has room, set by the single read and single write port of the
// pixel store with forwarding of the last write. A clear request closes the input until
// a clearing pass has zeroed every entry, one entry per cycle. Reset (rst, synchronous)
// starts the same pass; s_tready stays low until it ends, cfg writes are taken throughout.
// ---------------------------------------------------------------------------
// depth_point_splat_zbuffer
// Scatters stereo and lidar depth points into a tagged depth image in memory.
// ---------------------------------------------------------------------------
`default_nettype none

module depth_point_splat_zbuffer #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int DEPTH_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tdata: x_coord[9:0], y_coord[19:10], depth_in[43:20], zero pad[47:44]
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,
  // s_tuser: mode[1:0]
  input  wire logic [1:0]  s_tuser,
  // m_tdata: depth_out[23:0], source_out[25:24], was_written[26], zero pad[31:27]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,
  // m_tuser: status[0]
  output logic      [0:0]  m_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);

  localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int DW     = DEPTH_BITS;
  localparam int MW     = DW + dpsz_pkg::TAG_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);

  // Configuration registers
  logic [dpsz_pkg::CFG_W-1:0] image_width;
  logic [dpsz_pkg::CFG_W-1:0] image_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= dpsz_pkg::CFG_RESET;
      image_height <= dpsz_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index[0])
        dpsz_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        dpsz_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input decode
  logic [dpsz_pkg::COORD_W-1:0] x_coord;
  logic [dpsz_pkg::COORD_W-1:0] y_coord;
  logic [23:0]                  depth_in;
  dpsz_pkg::mode_t              mode;
  logic                         in_oor;
  logic [AW-1:0]                in_addr;
  logic                         accept;

  assign x_coord  = s_tdata[9:0];
  assign y_coord  = s_tdata[19:10];
  assign depth_in = s_tdata[43:20];
  assign mode     = dpsz_pkg::mode_t'(s_tuser);

  assign in_oor = ({1'b0, x_coord} >= image_width) || ({1'b0, y_coord} >= image_height) ||
                  (32'(x_coord) >= 32'(MAX_WIDTH)) || (32'(y_coord) >= 32'(MAX_HEIGHT));
  assign in_addr = AW'(32'(y_coord) * 32'(MAX_WIDTH) + 32'(x_coord));

  // Update stage registers
  logic            s1_valid;
  dpsz_pkg::mode_t s1_mode;
  logic            s1_oor;
  logic [AW-1:0]   s1_addr;
  logic [DW-1:0]   s1_depth;

  // Clearing pass
  logic          sweeping;
  logic [AW-1:0] sweep_addr;

  // Last write, for a read that was issued in the same cycle
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  logic [MW-1:0] fwd_data;

  logic [1:0] q_count;

  assign s_tready = !sweeping && !(s1_valid && (s1_mode == dpsz_pkg::MODE_CLEAR)) &&
                    ({1'b0, q_count} + {2'b00, s1_valid} <= 3'd2);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode  <= mode;
      s1_oor   <= in_oor;
      s1_addr  <= in_addr;
      s1_depth <= DW'(depth_in);
    end
  end

  // Memory
  logic [MW-1:0] rd_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [MW-1:0] mem_wr_data;
  logic          s1_wr;
  logic [MW-1:0] s1_wdata;

  assign mem_wr_en   = sweeping || s1_wr;
  assign mem_wr_addr = sweeping ? sweep_addr : s1_addr;
  assign mem_wr_data = sweeping ? '0 : s1_wdata;

  dpsz_mem #(
    .DEPTH (PIXELS),
    .AW    (AW),
    .DW    (MW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  // Read-modify-write
  logic [MW-1:0]                cur;
  logic [DW-1:0]                cur_depth;
  logic [dpsz_pkg::TAG_W-1:0]   cur_tag;
  dpsz_pkg::result_t            s1_result;

  assign cur       = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : rd_data;
  assign cur_depth = cur[DW-1:0];
  assign cur_tag   = cur[MW-1:DW];

  always_comb begin
    s1_wr     = 1'b0;
    s1_wdata  = {dpsz_pkg::TAG_STEREO, s1_depth};
    s1_result = '0;
    priority if (s1_mode == dpsz_pkg::MODE_CLEAR) begin
      s1_result = '0;
    end else if (s1_oor) begin
      s1_result.status = 1'b1;
    end else begin
      s1_result.depth_out  = dpsz_pkg::OUT_DEPTH_W'(cur_depth);
      s1_result.source_out = cur_tag;
      unique case (s1_mode)
        dpsz_pkg::MODE_STEREO: begin
          s1_wr    = s1_valid;
          s1_wdata = {dpsz_pkg::TAG_STEREO, s1_depth};
        end
        dpsz_pkg::MODE_LIDAR: begin
          // An empty pixel takes any lidar depth, even zero.
          if ((cur_depth == '0) || (s1_depth < cur_depth)) begin
            s1_wr    = s1_valid;
            s1_wdata = {dpsz_pkg::TAG_LIDAR, s1_depth};
          end
        end
        default: ;
      endcase
      if (s1_wr) begin
        s1_result.was_written = 1'b1;
        s1_result.depth_out   = dpsz_pkg::OUT_DEPTH_W'(s1_depth);
        s1_result.source_out  = s1_wdata[MW-1:DW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= s1_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      fwd_addr <= s1_addr;
      fwd_data <= s1_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end else if (sweeping) begin
      if (sweep_addr == LAST_ADDR) begin
        sweeping <= 1'b0;
      end
      sweep_addr <= sweep_addr + AW'(1);
    end else if (s1_valid && (s1_mode == dpsz_pkg::MODE_CLEAR)) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end
  end

  // Output queue
  dpsz_pkg::result_t q_data;

  dpsz_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (s1_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (q_data),
    .count     (q_count)
  );

  assign m_tdata = {5'b0, q_data.was_written, q_data.source_out, q_data.depth_out};
  assign m_tuser = q_data.status;

endmodule

`default_nettype wire

FILE: design/dpsz_checker.sv
// ---------------------------------------------------------------------------
// dpsz_checker
// Port-level checks of the depth point splat z-buffer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dpsz_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  // A flagged coordinate leaves the pixel alone and reports nothing.
  `ASSERT_IMPL(a_oor_empty, clk, rst, m_tvalid && m_tuser[0], m_tdata == 32'd0, "flagged result not empty")

  // A written pixel always carries a stereo or lidar tag.
  `ASSERT_IMPL(a_written_tagged, clk, rst, m_tvalid && m_tdata[26], m_tdata[25:24] != 2'd0, "written pixel untagged")

  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // The clearing pass after reset keeps the input closed.
  `ASSERT_IMPL(a_reset_sweep, clk, rst, $past(rst), !s_tready, "input open during clearing pass")

endmodule

bind depth_point_splat_zbuffer dpsz_checker u_dpsz_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/depth_point_splat_zbuffer_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// depth_point_splat_zbuffer_checker
// Watches the point, result and register channels of the z-buffer splat
// block, keeps its own depth image and tag image, works out the result of
// every accepted request and compares it field by field with what comes out.
// ---------------------------------------------------------------------------

module depth_point_splat_zbuffer_checker
  import dpsz_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [47:0]       s_tdata,
  input  logic [1:0]        s_tuser,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [31:0]       m_tdata,
  input  logic [0:0]        m_tuser,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [10:0]       cfg_data,
  output int unsigned       fail_count,
  output int unsigned       pending
);

  // Pixels that were never written since the last clear are simply absent.
  logic [OUT_DEPTH_W-1:0] depth_img [int];
  logic [TAG_W-1:0]       tag_img [int];
  logic [CFG_W-1:0]       img_width;
  logic [CFG_W-1:0]       img_height;
  result_t                expected_results [$];
  int unsigned            mismatches;

  initial begin
    fail_count = 0;
    pending    = 0;
    mismatches = 0;
    img_width  = CFG_RESET;
    img_height = CFG_RESET;
  end

  function automatic result_t splat_predict(mode_t mode, logic [COORD_W-1:0] x,
                                            logic [COORD_W-1:0] y,
                                            logic [OUT_DEPTH_W-1:0] depth);
    result_t                r;
    int                     key;
    logic [OUT_DEPTH_W-1:0] cur;
    r = '0;
    if (mode == MODE_CLEAR) begin
      depth_img.delete();
      tag_img.delete();
      return r;
    end
    if (x >= img_width || int'(x) >= MAX_WIDTH ||
        y >= img_height || int'(y) >= MAX_HEIGHT) begin
      r.status = 1'b1;
      return r;
    end
    key = int'(y) * MAX_WIDTH + int'(x);
    cur = depth_img.exists(key) ? depth_img[key] : '0;
    if (mode == MODE_STEREO) begin
      depth_img[key] = depth;
      tag_img[key]   = TAG_STEREO;
      r.was_written  = 1'b1;
    end else if (mode == MODE_LIDAR && (cur == '0 || depth < cur)) begin
      // A zero depth counts as empty, so a lidar point always lands there.
      depth_img[key] = depth;
      tag_img[key]   = TAG_LIDAR;
      r.was_written  = 1'b1;
    end
    r.depth_out  = depth_img.exists(key) ? depth_img[key] : '0;
    r.source_out = tag_img.exists(key) ? tag_img[key] : TAG_NONE;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      depth_img.delete();
      tag_img.delete();
      expected_results.delete();
      img_width  = CFG_RESET;
      img_height = CFG_RESET;
      pending   <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IMAGE_WIDTH)
          img_width = cfg_data;
        else
          img_height = cfg_data;
      end

      if (m_tvalid && m_tready) begin
        got.depth_out   = m_tdata[23:0];
        got.source_out  = m_tdata[25:24];
        got.was_written = m_tdata[26];
        got.status      = m_tuser[0];
        if (expected_results.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("%0t: result with no request pending: depth %h tag %0d wr %0b st %0b",
                     $realtime, got.depth_out, got.source_out, got.was_written,
                     got.status);
        end else begin
          want = expected_results.pop_front();
          if (got.depth_out != want.depth_out || got.source_out != want.source_out ||
              got.was_written != want.was_written || got.status != want.status) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("%0t: mismatch expected depth %h tag %0d wr %0b st %0b, got depth %h tag %0d wr %0b st %0b",
                       $realtime, want.depth_out, want.source_out, want.was_written,
                       want.status, got.depth_out, got.source_out, got.was_written,
                       got.status);
          end
        end
      end

      if (s_tvalid && s_tready)
        expected_results.insert(expected_results.size(),
                                splat_predict(mode_t'(s_tuser), s_tdata[9:0],
                                              s_tdata[19:10], s_tdata[43:20]));

      pending    <= expected_results.size();
      fail_count <= mismatches;
    end
  end

endmodule

FILE: tb/depth_point_splat_zbuffer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// depth_point_splat_zbuffer_tb
// Drives stereo, lidar, read and clear requests into the z-buffer splat block
// under several image sizes, with random gaps and output stalls, and reports
// the verdict from the checker's failure count.
// ---------------------------------------------------------------------------

module depth_point_splat_zbuffer_tb;
  import dpsz_pkg::*;

  localparam int          MAX_W       = 1024;
  localparam int          MAX_H       = 1024;
  // Two full clearing passes dominate the run.
  localparam int unsigned LIMIT       = 8_000_000;
  localparam int          PHASE_ITEMS = 175;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  bit          quiet = 1'b0;
  int unsigned cycles = 0;
  int unsigned fail_count;
  int unsigned pending;

  depth_point_splat_zbuffer #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .DEPTH_BITS(24)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  depth_point_splat_zbuffer_checker #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) splat_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 29);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("depth_point_splat_zbuffer_tb: FAIL");
      $finish;
    end
  end

  task automatic set_image_size(input logic [10:0] w, input logic [10:0] h);
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= w;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_point(input mode_t mode, input logic [9:0] x, input logic [9:0] y,
                            input logic [23:0] depth);
    if (!quiet && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 29);
    end
    s_tuser  <= mode;
    s_tdata  <= {4'b0, depth, y, x};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Leaves the block idle: waits until every expected result has come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_phase(input logic [10:0] w, input logic [10:0] h, input int count);
    logic [9:0]  hot_x;
    logic [9:0]  hot_y;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [23:0] depth;
    mode_t       mode;
    int          pick;
    set_image_size(w, h);
    hot_x = 10'($urandom_range(0, w - 1));
    hot_y = 10'($urandom_range(0, h - 1));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      mode = (pick < 30) ? MODE_STEREO : (pick < 70) ? MODE_LIDAR : MODE_READ;
      // Mostly a small cluster of pixels, so that lidar and reads meet earlier writes.
      pick = $urandom_range(99);
      if (pick < 75) begin
        x = hot_x + 10'($urandom_range(0, 2));
        y = hot_y + 10'($urandom_range(0, 2));
      end else if (pick < 90) begin
        x = 10'($urandom);
        y = 10'($urandom);
      end else begin
        x = 10'(w - 1 + $urandom_range(0, 1));
        y = 10'(h - 1 + $urandom_range(0, 1));
      end
      depth = ($urandom_range(1) == 0) ? 24'($urandom_range(0, 15)) : 24'($urandom);
      send_point(mode, x, y, depth);
    end
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    set_image_size(11'd1024, 11'd1024);

    send_point(MODE_READ,   10'd0,   10'd0,   24'h000000);
    send_point(MODE_STEREO, 10'd0,   10'd0,   24'hFFFFFF);
    send_point(MODE_LIDAR,  10'd0,   10'd0,   24'hFFFFFF);
    send_point(MODE_LIDAR,  10'd0,   10'd0,   24'hFFFFFE);
    send_point(MODE_STEREO, 10'd0,   10'd0,   24'h000000);
    // Stored depth is zero now, so even the farthest lidar point replaces it.
    send_point(MODE_LIDAR,  10'd0,   10'd0,   24'hFFFFFF);
    send_point(MODE_STEREO, 10'd1023, 10'd1023, 24'h123456);
    send_point(MODE_STEREO, 10'd1023, 10'd1023, 24'h123456);
    send_point(MODE_LIDAR,  10'd1023, 10'd1023, 24'h123457);
    send_point(MODE_LIDAR,  10'd1023, 10'd1023, 24'h000001);
    send_point(MODE_LIDAR,  10'd5,   10'd7,   24'h000000);
    send_point(MODE_LIDAR,  10'd5,   10'd7,   24'h000000);
    send_point(MODE_READ,   10'd1023, 10'd1023, 24'hFFFFFF);
    send_point(MODE_READ,   10'd5,   10'd7,   24'h000000);
    send_point(MODE_CLEAR,  10'd1023, 10'd1023, 24'hFFFFFF);
    send_point(MODE_READ,   10'd0,   10'd0,   24'h000000);
    send_point(MODE_READ,   10'd1023, 10'd1023, 24'h000000);
    send_point(MODE_READ,   10'd5,   10'd7,   24'h000000);
    drain_results();

    set_image_size(11'd1, 11'd1);
    send_point(MODE_STEREO, 10'd0,   10'd0,   24'hABCDEF);
    send_point(MODE_STEREO, 10'd1,   10'd0,   24'h000010);
    send_point(MODE_LIDAR,  10'd0,   10'd1,   24'h000001);
    send_point(MODE_READ,   10'd1023, 10'd0,   24'h000000);
    send_point(MODE_READ,   10'd0,   10'd0,   24'h000000);
    drain_results();

    run_phase(11'd16, 11'd16, PHASE_ITEMS);
    run_phase(11'd1024, 11'd1024, PHASE_ITEMS);
    run_phase(11'd1, 11'd1024, PHASE_ITEMS);
    quiet <= 1'b1;
    run_phase(11'd8, 11'd8, PHASE_ITEMS);
    quiet <= 1'b0;
    run_phase(11'd1024, 11'd1, PHASE_ITEMS);
    run_phase(11'd37, 11'd5, PHASE_ITEMS);
    run_phase(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)), PHASE_ITEMS);

    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("depth_point_splat_zbuffer_tb: PASS");
    else
      $display("depth_point_splat_zbuffer_tb: FAIL");
    $finish;
  end

endmodule

FILE: depth_point_splat_zbuffer.f
+incdir+design
design/dpsz_pkg.sv
design/dpsz_mem.sv
design/dpsz_outq.sv
design/depth_point_splat_zbuffer.sv
design/dpsz_checker.sv
tb/depth_point_splat_zbuffer_checker.sv
tb/depth_point_splat_zbuffer_tb.sv
